// File: sv/steo_pkg.sv
// Shared widths, the pipeline word and the arctangent table of the structure tensor unit.
`timescale 1ns / 1ps

package steo_pkg;

    localparam int DATA_W      = 24;
    localparam int DX_W        = DATA_W + 1;
    localparam int TR_W        = DATA_W + 1;
    localparam int RAD_W       = 2 * DX_W;
    localparam int ROOT_W      = DX_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int EIG_W       = DATA_W + 2;
    localparam int CW          = 34;
    localparam int ACC_W       = 32;
    localparam int NORM_BIT    = 29;
    localparam int MAG_W       = NORM_BIT + 1;
    localparam int ORIENT_W    = 16;
    localparam int ANGLE_STEPS = 18;
    localparam int NUM_CELLS   = ROOT_W;
    localparam int IDX_W       = 5;

    // One pixel as it travels down the row of cells.
    typedef struct packed {
        logic [TR_W-1:0]   tr;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ACC_W-1:0]  acc;
        logic              zero;
    } pl_t;

    // atan(2^-i) with one full turn equal to 2^32, truncated.
    function automatic logic [ACC_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
        logic [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/steo_front.sv
// Front end: difference, trace, squares, vector normalization and radicand.
`timescale 1ns / 1ps

module steo_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [steo_pkg::DATA_W-1:0]   sum_xx,
    input  logic [steo_pkg::DATA_W-1:0]   sum_xy,
    input  logic [steo_pkg::DATA_W-1:0]   sum_yy,
    output logic                          out_valid,
    output steo_pkg::pl_t                 out_data
);
    import steo_pkg::*;

    logic                   v0_reg, v1_reg, v2_reg;
    logic signed [DX_W-1:0] dx0_reg, c0_reg;
    logic [TR_W-1:0]        tr0_reg, tr1_reg;
    logic signed [DX_W-1:0] dx_next, c_next;
    logic [TR_W-1:0]        tr_next;
    logic [DX_W-1:0]        mdx, mc;
    logic [RAD_W-1:0]       sqa_reg, sqc_reg;
    logic signed [CW-1:0]   xn, yn;
    logic [CW-1:0]          mx, my;
    logic [MAG_W-1:0]       m;
    logic [ACC_W-1:0]       acc_n;
    logic signed [CW-1:0]   x1_reg, y1_reg;
    logic [ACC_W-1:0]       acc1_reg;
    logic                   zero1_reg;
    pl_t                    out_reg;

    assign dx_next = $signed({1'b0, sum_xx}) - $signed({1'b0, sum_yy});
    assign c_next  = $signed({sum_xy, 1'b0});
    assign tr_next = {1'b0, sum_xx} + {1'b0, sum_yy};

    assign mdx = dx0_reg[DX_W-1] ? DX_W'(-dx0_reg) : DX_W'(dx0_reg);
    assign mc  = c0_reg[DX_W-1]  ? DX_W'(-c0_reg)  : DX_W'(c0_reg);

    // Vectors in the left half plane are turned by half a turn, then both
    // components are scaled up until the larger magnitude reaches 2^29.
    always_comb
    begin
        xn    = CW'(dx0_reg);
        yn    = CW'(c0_reg);
        acc_n = '0;
        if (dx0_reg[DX_W-1])
        begin
            xn    = -xn;
            yn    = -yn;
            acc_n = ACC_W'(1) << (ACC_W - 1);
        end
        mx = xn[CW-1] ? CW'(-xn) : CW'(xn);
        my = yn[CW-1] ? CW'(-yn) : CW'(yn);
        m  = MAG_W'(mx | my);
        for (int k = 4; k >= 0; k--)
        begin
            if (m < (MAG_W'(1) << (MAG_W - (1 << k))))
            begin
                m  = m << (1 << k);
                xn = xn <<< (1 << k);
                yn = yn <<< (1 << k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx0_reg   <= dx_next;
            c0_reg    <= c_next;
            tr0_reg   <= tr_next;
            sqa_reg   <= RAD_W'(mdx * mdx);
            sqc_reg   <= RAD_W'(mc * mc);
            tr1_reg   <= tr0_reg;
            x1_reg    <= xn;
            y1_reg    <= yn;
            acc1_reg  <= acc_n;
            zero1_reg <= (dx0_reg == '0) && (c0_reg == '0);
            out_reg.tr   <= tr1_reg;
            out_reg.rad  <= sqa_reg + sqc_reg;
            out_reg.rem  <= '0;
            out_reg.root <= '0;
            out_reg.x    <= x1_reg;
            out_reg.y    <= y1_reg;
            out_reg.acc  <= acc1_reg;
            out_reg.zero <= zero1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = out_reg;

endmodule

// File: sv/steo_cell.sv
// One cell of the row: one square root digit and, in the first 18 steps, one CORDIC rotation.
`timescale 1ns / 1ps

module steo_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [steo_pkg::IDX_W-1:0]  step_idx,
    input  logic                        in_valid,
    input  steo_pkg::pl_t               in_data,
    output logic                        out_valid,
    output steo_pkg::pl_t               out_data
);
    import steo_pkg::*;

    logic                 valid_reg;
    pl_t                  data_reg;
    pl_t                  data_next;
    logic [REM_W-1:0]     rem_sh, trial;
    logic signed [CW-1:0] xs, ys;

    always_comb
    begin
        data_next = in_data;
        rem_sh = {in_data.rem[REM_W-3:0], in_data.rad[RAD_W-1 -: 2]};
        trial  = {in_data.root, 2'b01};
        data_next.rad = in_data.rad << 2;
        if (rem_sh >= trial)
        begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh;
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
        end

        xs = in_data.x >>> step_idx;
        ys = in_data.y >>> step_idx;
        if (step_idx < IDX_W'(ANGLE_STEPS))
        begin
            if (in_data.y > 0)
            begin
                data_next.x   = in_data.x + ys;
                data_next.y   = in_data.y - xs;
                data_next.acc = in_data.acc + atan_lut(step_idx);
            end
            else
            begin
                data_next.x   = in_data.x - ys;
                data_next.y   = in_data.y + xs;
                data_next.acc = in_data.acc - atan_lut(step_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: sv/structure_tensor_eigen_orient_unit.sv
// Top level of the structure tensor eigenvalue and orientation unit.
`timescale 1ns / 1ps

// Per pixel this unit takes the tensor sums Cxx, Cxy and Cyy and returns
// Cxx+Cyy+D and Cxx+Cyy-D, where D is the exact floor of the square root of
// (Cxx-Cyy)^2 + (2*Cxy)^2, together with the orientation: half the angle of
// the vector (Cxx-Cyy, 2*Cxy) in units of pi/65536, zero when the vector is
// zero. It accepts one transaction every clock cycle while not stalled and
// returns one result transaction for each, in order. The path holds 29
// register stages: three front stages (difference and trace, squares and
// vector normalization, radicand sum), a row of 25 identical cells that
// each produce one bit of the root and, in the first 18, perform one CORDIC
// rotation, and the output register. The first stage loads at the
// accepting edge. The whole pipeline advances together; it stalls only
// while a finished result waits at the output and out_ready is low, so
// in_ready follows out_ready when the output is full.

module structure_tensor_eigen_orient_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [steo_pkg::DATA_W-1:0]        sum_xx,
    input  logic signed [steo_pkg::DATA_W-1:0] sum_xy,
    input  logic [steo_pkg::DATA_W-1:0]        sum_yy,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [steo_pkg::EIG_W-1:0]         eig_large,
    output logic signed [steo_pkg::EIG_W-1:0]  eig_small,
    output logic [steo_pkg::ORIENT_W-1:0]      orientation
);
    import steo_pkg::*;

    logic                    en;
    logic [NUM_CELLS:0]      chain_valid;
    pl_t                     chain_data [NUM_CELLS+1];
    logic                    out_valid_reg;
    logic [EIG_W-1:0]        eig_large_reg;
    logic signed [EIG_W-1:0] eig_small_reg;
    logic [ORIENT_W-1:0]     orient_reg;
    logic [ACC_W-1:0]        acc_rnd;
    pl_t                     last;

    // Every stage moves when the output register is empty or being drained.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    steo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .sum_xx    (sum_xx),
        .sum_xy    (sum_xy),
        .sum_yy    (sum_yy),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // The row of cells; cell i resolves root bit 24-i and, for i below 18, CORDIC step i.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        steo_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step_idx  (IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign last = chain_data[NUM_CELLS];

    // Round half up to 16 bits of angle; a full turn wraps to zero.
    assign acc_rnd = last.acc + (ACC_W'(1) << (ACC_W - ORIENT_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= chain_valid[NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eig_large_reg <= EIG_W'(last.tr) + EIG_W'(last.root);
            eig_small_reg <= $signed(EIG_W'(last.tr) - EIG_W'(last.root));
            orient_reg    <= last.zero ? '0 : acc_rnd[ACC_W-1 -: ORIENT_W];
        end
    end

    assign out_valid   = out_valid_reg;
    assign eig_large   = eig_large_reg;
    assign eig_small   = eig_small_reg;
    assign orientation = orient_reg;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the structure tensor eigenvalue and orientation unit.
`timescale 1ns / 1ps

// The testbench drives pixels of tensor sums into the unit over a valid/ready
// channel and checks every result transaction against an internal predictor.
// The predictor computes the exact integer root of (Cxx-Cyy)^2 + (2*Cxy)^2,
// the two scaled eigenvalues and a bit-true CORDIC estimate of the half angle.
// The orientation is accepted within one LSB, with wrap at a full turn.
// Tests run in turn: directed corner pixels, random pixels with random idling,
// a long output stall that fills the pipeline, and a pause that drains it.

module testbench;

    import steo_pkg::*;

    localparam int LATENCY     = 28;
    localparam int WATCHDOG    = 5000;
    localparam int HOLD_CYCLES = 200;
    localparam int N_RANDOM    = 1900;

    // One expected result of the unit.
    typedef struct {
        logic [EIG_W-1:0]    big_eig;
        logic [EIG_W-1:0]    small_eig;
        logic [ORIENT_W-1:0] angle;
    } eig_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [DATA_W-1:0] sum_xx;
    logic signed [DATA_W-1:0] sum_xy;
    logic [DATA_W-1:0] sum_yy;
    logic out_valid;
    logic out_ready;
    logic [EIG_W-1:0] eig_large;
    logic signed [EIG_W-1:0] eig_small;
    logic [ORIENT_W-1:0] orientation;

    // Results still owed by the unit, oldest first.
    eig_result_t pending_results[$];
    int errors;
    int pixels_sent;
    int results_seen;
    int idle_cycles;
    bit no_gaps;    // when set, neither side idles
    bit hold_req;   // asks the receiver for one long stall

    structure_tensor_eigen_orient_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sum_xx(sum_xx),
        .sum_xy(sum_xy),
        .sum_yy(sum_yy),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .eig_large(eig_large),
        .eig_small(eig_small),
        .orientation(orientation)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Full angle of the vector (x, y) in units of one turn = 2^32, by CORDIC
    // vectoring after normalizing the larger magnitude to at least 2^29.
    function automatic logic [ACC_W-1:0] cordic_angle(input longint x, input longint y);
        logic [ACC_W-1:0] acc;
        longint xs;
        longint ys;
        acc = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = 32'h80000000;
        end
        while ((x < 0 ? -x : x) < (64'sd1 << NORM_BIT) && (y < 0 ? -y : y) < (64'sd1 << NORM_BIT))
        begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < ANGLE_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                acc = acc + atan_lut(i[IDX_W-1:0]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                acc = acc - atan_lut(i[IDX_W-1:0]);
            end
        end
        return acc;
    endfunction

    function automatic eig_result_t predict_eigen(input logic [DATA_W-1:0] xx,
                                                  input logic signed [DATA_W-1:0] xy,
                                                  input logic [DATA_W-1:0] yy);
        eig_result_t r;
        longint dx;
        longint c;
        longint tr;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned t;
        logic [ACC_W-1:0] acc;
        dx = longint'(xx) - longint'(yy);
        c = 2 * longint'(xy);
        tr = longint'(xx) + longint'(yy);
        rad = longint'(dx * dx) + longint'(c * c);
        root = 0;
        for (int b = 26; b >= 0; b--)
        begin
            t = root | (64'd1 << b);
            if (t * t <= rad)
                root = t;
        end
        r.big_eig = EIG_W'(tr + longint'(root));
        r.small_eig = EIG_W'(tr - longint'(root));
        r.angle = '0;
        if (dx != 0 || c != 0)
        begin
            acc = cordic_angle(dx, c);
            r.angle = ORIENT_W'((acc + 32'h8000) >> 16);
        end
        return r;
    endfunction

    // Offers one pixel after a random gap and returns at the falling edge
    // after it was accepted. Valid stays high when the next gap is zero.
    task automatic send_pixel(input logic [DATA_W-1:0] xx, input logic [DATA_W-1:0] xy,
                              input logic [DATA_W-1:0] yy);
        int gap;
        bit taken;
        gap = no_gaps ? 0 : int'($urandom_range(8));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sum_xx <= xx;
        sum_xy <= xy;
        sum_yy <= yy;
        taken = 1'b0;
        while (!taken)
        begin
            #1;
            taken = in_ready;
            @(posedge clk);
            if (taken)
            begin
                pending_results.insert(pending_results.size(), predict_eigen(xx, xy, yy));
                pixels_sent++;
            end
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Corner pixels: field extremes, zero vector, left half plane, axes.
    task automatic test_directed();
        no_gaps = 1'b1;
        send_pixel(24'h000000, 24'h000000, 24'h000000);
        send_pixel(24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        send_pixel(24'hFFFFFF, 24'h7FFFFF, 24'h000000);
        send_pixel(24'hFFFFFF, 24'h800000, 24'h000000);
        send_pixel(24'h000000, 24'h800000, 24'hFFFFFF);
        send_pixel(24'h000000, 24'h7FFFFF, 24'hFFFFFF);
        send_pixel(24'h000000, 24'h000000, 24'hFFFFFF);
        send_pixel(24'hFFFFFF, 24'h000000, 24'h000000);
        send_pixel(24'h000001, 24'h000000, 24'h000000);
        send_pixel(24'h000000, 24'h000000, 24'h000001);
        send_pixel(24'h000000, 24'h000001, 24'h000000);
        send_pixel(24'h000000, 24'hFFFFFF, 24'h000000);
        send_pixel(24'h000100, 24'h000080, 24'h000000);
        send_pixel(24'h000000, 24'hFFFF80, 24'h000100);
        send_pixel(24'h000000, 24'h000080, 24'h000100);
        send_pixel(24'h123456, 24'h000000, 24'h123456);
        send_pixel(24'hAAAAAA, 24'h555555, 24'h555555);
        send_pixel(24'h555555, 24'hAAAAAA, 24'hAAAAAA);
        send_pixel(24'h000003, 24'hFFFFFF, 24'h000005);
        send_pixel(24'h800000, 24'h400000, 24'h7FFFFF);
        no_gaps = 1'b0;
        send_pixel(24'h000002, 24'h000001, 24'h000004);
        wait_drained();
    endtask

    // Random pixels: full range, small magnitudes that need normalizing,
    // equal diagonals and near-axis vectors, with stretches of no idling.
    task automatic test_random(input int count);
        logic [DATA_W-1:0] xx;
        logic [DATA_W-1:0] xy;
        logic [DATA_W-1:0] yy;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            if (n % 300 == 0)
                no_gaps = (n % 600 == 0);
            sel = int'($urandom_range(4));
            xx = DATA_W'($urandom);
            xy = DATA_W'($urandom);
            yy = DATA_W'($urandom);
            case (sel)
                1:
                begin
                    xx = DATA_W'($urandom_range(255));
                    yy = DATA_W'($urandom_range(255));
                    xy = DATA_W'($signed($urandom_range(255)) - 128);
                end
                2: yy = xx;
                3: xy = DATA_W'($signed($urandom_range(7)) - 4);
                default: ;
            endcase
            send_pixel(xx, xy, yy);
        end
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // The receiver stalls for a long stretch while pixels keep coming.
    task automatic test_backpressure();
        no_gaps = 1'b1;
        hold_req = 1'b1;
        for (int n = 0; n < 80; n++)
            send_pixel(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // The sender pauses until every result is back, then restarts.
    task automatic test_drain_pause();
        for (int n = 0; n < 20; n++)
            send_pixel(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
        wait_drained();
        repeat (LATENCY) @(negedge clk);
        for (int n = 0; n < 20; n++)
            send_pixel(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
        wait_drained();
    endtask

    // Receiver side: random stalls per result, or one long hold on request.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = no_gaps ? 0 : int'($urandom_range(8));
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Checks each result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        eig_result_t exp_r;
        logic [ORIENT_W-1:0] diff;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no pixel outstanding");
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (eig_large !== exp_r.big_eig)
                begin
                    $error("eig_large expected %0d got %0d", exp_r.big_eig, eig_large);
                    errors++;
                end
                if (eig_small !== exp_r.small_eig)
                begin
                    $error("eig_small expected %0d got %0d",
                           $signed(exp_r.small_eig), eig_small);
                    errors++;
                end
                diff = orientation - exp_r.angle;
                if ($isunknown(orientation) || !(diff == 0 || diff == 1 || diff == 16'hFFFF))
                begin
                    $error("orientation expected %0d got %0d", exp_r.angle, orientation);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel completes a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("timeout after %0d cycles without a transaction", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        pixels_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sum_xx = '0;
        sum_xy = '0;
        sum_yy = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(N_RANDOM);
        test_backpressure();
        test_drain_pause();

        repeat (LATENCY + 10) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("Covered %0d pixels and %0d results: corners, random sums, long stall, drain.",
                 pixels_sent, results_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
sv/steo_pkg.sv
sv/steo_front.sv
sv/steo_cell.sv
sv/structure_tensor_eigen_orient_unit.sv
test/testbench.sv
